>>> rtl/jssm_pkg.sv
package jssm_pkg;

  // Number format and field widths
  localparam int AXIS_FRAC_BITS = 15;
  localparam int AXIS_W         = 16;
  localparam int ANGLE_W        = 9;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int DIV_BIT_W      = $clog2(ANGLE_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ANGLE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_ANGLE    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_TRAVEL  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_TRAVEL   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_STEPS  = 4'd7;

  // Reset values
  localparam logic [ANGLE_W-1:0]    RST_ANGLE_MIN     = 9'd0;
  localparam logic [ANGLE_W-1:0]    RST_ANGLE_MAX     = 9'd270;
  localparam logic [ANGLE_W-1:0]    RST_DEFAULT_ANGLE = 9'd150;
  localparam logic [ANGLE_W-1:0]    RST_HOME_ANGLE    = 9'd150;
  localparam logic [ANGLE_W-1:0]    RST_STICK_TRAVEL  = 9'd150;
  localparam logic [ANGLE_W-1:0]    RST_TRIG_TRAVEL   = 9'd100;
  localparam logic [CFG_DATA_W-1:0] RST_DEADBAND      = 32'h0CCD_2666;
  localparam logic [CFG_DATA_W-1:0] RST_MOTION_STEPS  = 32'h0F02_0101;
  localparam logic [ANGLE_W-1:0]    RST_SERVO         = 9'd150;

  // Axis being worked on
  typedef enum logic [1:0] {
    AX_Y  = 2'd0,
    AX_X  = 2'd1,
    AX_RT = 2'd2,
    AX_LT = 2'd3
  } ax_t;

  typedef struct packed {
    logic                        pad_present;
    logic signed [AXIS_W-1:0]    stick_x;
    logic signed [AXIS_W-1:0]    stick_y;
    logic signed [AXIS_W-1:0]    left_trigger;
    logic signed [AXIS_W-1:0]    right_trigger;
    logic                        hold_button;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_up;
    logic [ANGLE_W-1:0] angle_right;
    logic [ANGLE_W-1:0] angle_down;
    logic [ANGLE_W-1:0] angle_left;
    logic [ANGLE_W-1:0] angle_rtrig;
    logic [ANGLE_W-1:0] angle_ltrig;
    logic [ANGLE_W-1:0] angle_bump;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic                 load;
    ax_t                  ax;
    logic                 mul;
    logic                 div_init;
    logic                 div_step;
    logic [DIV_BIT_W-1:0] div_bit;
    logic                 store;
    logic                 tgt;
    logic                 slew;
    logic                 out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pad;
    logic changed;
  } status_t;

endpackage

>>> rtl/jssm_ctrl.sv
module jssm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  jssm_pkg::status_t st,
  output jssm_pkg::cmd_t   cmd
);
  import jssm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_STORE,
    S_TGT,
    S_SLEW,
    S_OUT
  } state_t;

  localparam logic [DIV_BIT_W-1:0] TOP_BIT = DIV_BIT_W'(ANGLE_W - 1);

  state_t               state_r, state_nxt;
  ax_t                  ax_r, ax_nxt;
  logic [DIV_BIT_W-1:0] bit_r, bit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 is_stick;

  assign is_stick  = (ax_r == AX_Y) || (ax_r == AX_X);
  // no transfer is taken while in reset
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Commands and next state
  always_comb begin
    cmd           = '0;
    cmd.ax        = ax_r;
    cmd.div_bit   = bit_r;
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.pad) begin
            ax_nxt    = AX_Y;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = is_stick ? S_DINIT : S_STORE;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        bit_nxt      = TOP_BIT;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_r == '0) state_nxt = S_STORE;
        else bit_nxt = bit_r - 1'b1;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (ax_r == AX_LT) begin
          state_nxt = S_TGT;
        end else begin
          ax_nxt    = ax_t'(ax_r + 2'd1);
          state_nxt = S_MUL;
        end
      end
      S_TGT: begin
        cmd.tgt   = 1'b1;
        state_nxt = S_SLEW;
      end
      S_SLEW: begin
        cmd.slew  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!st.changed) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= AX_Y;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/jssm_dp.sv
module jssm_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  jssm_pkg::in_item_t                   in_data,
  output jssm_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [jssm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jssm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  jssm_pkg::cmd_t                       cmd,
  output jssm_pkg::status_t                    st
);
  import jssm_pkg::*;

  localparam int NSERVO    = 7;
  localparam int MAG_SHIFT = 16 - AXIS_FRAC_BITS;
  localparam int TRG_SHIFT = 15 - AXIS_FRAC_BITS;
  localparam int A_W       = 32 - AXIS_FRAC_BITS;
  localparam int P_W       = 17;
  localparam int PROD_W    = ANGLE_W + P_W;
  localparam int REM_W     = PROD_W + 1;
  localparam logic signed [17:0] TRG_ONE  = 18'(1 << AXIS_FRAC_BITS);
  localparam logic signed [17:0] TRG_FULL = 18'(1 << (AXIS_FRAC_BITS + 1));
  localparam logic [P_W-1:0]     FULL_Q16 = 17'h10000;
  localparam logic [REM_W-1:0]   HALF_Q16 = REM_W'(32768);

  // Clamp to the angle limits; when they cross, values below the low limit give it and all others the high limit
  function automatic logic [ANGLE_W-1:0] lim(input logic [ANGLE_W+1:0] a,
                                             input logic [ANGLE_W-1:0] mn,
                                             input logic [ANGLE_W-1:0] mx);
    logic [ANGLE_W-1:0] r;
    if (a < {2'b0, mn})      r = mn;
    else if (a > {2'b0, mx}) r = mx;
    else                     r = a[ANGLE_W-1:0];
    return r;
  endfunction

  // One slew step towards the target; a zero step acts as one
  function automatic logic [ANGLE_W-1:0] slew(input logic [ANGLE_W-1:0] cur,
                                              input logic [ANGLE_W-1:0] tgt,
                                              input logic [7:0]         stp);
    logic [ANGLE_W:0]   s;
    logic [ANGLE_W:0]   up;
    logic [ANGLE_W:0]   lo;
    logic [ANGLE_W-1:0] r;
    s  = (stp == 8'd0) ? (ANGLE_W+1)'(1) : (ANGLE_W+1)'(stp);
    up = {1'b0, cur} + s;
    lo = {1'b0, tgt} + s;
    r  = cur;
    if (cur < tgt)      r = (up < {1'b0, tgt}) ? up[ANGLE_W-1:0] : tgt;
    else if (cur > tgt) r = (lo < {1'b0, cur}) ? ANGLE_W'(cur - s) : tgt;
    return r;
  endfunction

  // Configuration registers
  logic [ANGLE_W-1:0]    amin_r, amax_r, dflt_r, home_r, stv_r, ttv_r;
  logic [CFG_DATA_W-1:0] dband_r, steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amin_r  <= RST_ANGLE_MIN;
      amax_r  <= RST_ANGLE_MAX;
      dflt_r  <= RST_DEFAULT_ANGLE;
      home_r  <= RST_HOME_ANGLE;
      stv_r   <= RST_STICK_TRAVEL;
      ttv_r   <= RST_TRIG_TRAVEL;
      dband_r <= RST_DEADBAND;
      steps_r <= RST_MOTION_STEPS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_MIN:     amin_r  <= cfg_wdata[ANGLE_W-1:0];
        REG_ANGLE_MAX:     amax_r  <= cfg_wdata[ANGLE_W-1:0];
        REG_DEFAULT_ANGLE: dflt_r  <= cfg_wdata[ANGLE_W-1:0];
        REG_HOME_ANGLE:    home_r  <= cfg_wdata[ANGLE_W-1:0];
        REG_STICK_TRAVEL:  stv_r   <= cfg_wdata[ANGLE_W-1:0];
        REG_TRIG_TRAVEL:   ttv_r   <= cfg_wdata[ANGLE_W-1:0];
        REG_DEADBAND:      dband_r <= cfg_wdata;
        REG_MOTION_STEPS:  steps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [15:0] sdb, tdb;
  assign sdb = dband_r[15:0];
  assign tdb = dband_r[31:16];

  // Captured item
  in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end
  assign st.pad = in_data.pad_present;

  // Axis selection
  logic signed [AXIS_W-1:0] raw;
  always_comb begin
    unique case (cmd.ax)
      AX_Y:    raw = item_r.stick_y;
      AX_X:    raw = item_r.stick_x;
      AX_RT:   raw = item_r.right_trigger;
      AX_LT:   raw = item_r.left_trigger;
      default: raw = item_r.stick_y;
    endcase
  end

  // Stick magnitude past the deadband
  logic [AXIS_W-1:0] mag;
  logic [A_W-1:0]    amag, num;
  logic [16:0]       den;
  logic              s_act, s_sat;
  assign mag   = raw[AXIS_W-1] ? AXIS_W'(-raw) : AXIS_W'(raw);
  assign amag  = A_W'(mag) << MAG_SHIFT;
  assign s_act = amag > A_W'(sdb);
  assign num   = amag - A_W'(sdb);
  assign den   = FULL_Q16 - {1'b0, sdb};
  assign s_sat = num >= A_W'(den);

  // Trigger press (1 - raw) / 2 with cutoff
  logic signed [17:0] tn;
  logic [17:0]        tcl;
  logic [P_W-1:0]     tp, tpd;
  assign tn  = TRG_ONE - 18'($signed(raw));
  assign tcl = tn[17] ? 18'd0 : ((tn > TRG_FULL) ? TRG_FULL : tn);
  assign tp  = P_W'(tcl << TRG_SHIFT);
  assign tpd = (tp < {1'b0, tdb}) ? '0 : tp;

  // Shared multiplier
  logic              is_stick;
  logic [ANGLE_W-1:0] mul_a;
  logic [P_W-1:0]     mul_b;
  assign is_stick = (cmd.ax == AX_Y) || (cmd.ax == AX_X);
  assign mul_a    = is_stick ? stv_r : ttv_r;
  assign mul_b    = is_stick ? {num[15:0], 1'b0} : tpd;

  logic [PROD_W-1:0] prod_r;
  logic [16:0]       den_r;
  logic              sat_r;
  logic              y_act_r, y_neg_r, x_act_r, x_neg_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      den_r  <= den;
      sat_r  <= s_sat;
      if (cmd.ax == AX_Y) begin
        y_act_r <= s_act;
        y_neg_r <= raw[AXIS_W-1];
      end
      if (cmd.ax == AX_X) begin
        x_act_r <= s_act;
        x_neg_r <= raw[AXIS_W-1];
      end
    end
  end

  // Restoring division, one quotient bit a cycle
  logic [REM_W-1:0]   rem_r, dsh;
  logic [ANGLE_W-1:0] q_r;
  assign dsh = REM_W'({den_r, 1'b0}) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= REM_W'(prod_r) + REM_W'(den_r);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh) begin
        rem_r              <= rem_r - dsh;
        q_r[cmd.div_bit]   <= 1'b1;
      end
    end
  end

  // Degrees added per axis
  logic [REM_W-1:0]   trnd;
  logic [ANGLE_W-1:0] deg_y_r, deg_x_r, deg_rt_r, deg_lt_r;
  assign trnd = REM_W'(prod_r) + HALF_Q16;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      unique case (cmd.ax)
        AX_Y:    deg_y_r  <= sat_r ? stv_r : q_r;
        AX_X:    deg_x_r  <= sat_r ? stv_r : q_r;
        AX_RT:   deg_rt_r <= trnd[16 +: ANGLE_W];
        AX_LT:   deg_lt_r <= trnd[16 +: ANGLE_W];
        default: ;
      endcase
    end
  end

  // Targets
  logic [ANGLE_W-1:0] servo_r [NSERVO];
  logic [ANGLE_W-1:0] tgt_r   [NSERVO];
  logic [ANGLE_W-1:0] tgt_nxt [NSERVO];
  logic [ANGLE_W-1:0] base_r, base_nxt;
  logic               held_r;
  logic [ANGLE_W-1:0] yt, xt;

  assign yt = lim((ANGLE_W+2)'(home_r) + (ANGLE_W+2)'(deg_y_r), amin_r, amax_r);
  assign xt = lim((ANGLE_W+2)'(home_r) + (ANGLE_W+2)'(deg_x_r), amin_r, amax_r);
  assign base_nxt = (item_r.hold_button && !held_r) ? servo_r[6] : base_r;

  always_comb begin
    tgt_nxt[0] = (y_act_r && !y_neg_r) ? yt : home_r;
    tgt_nxt[2] = (y_act_r &&  y_neg_r) ? yt : home_r;
    tgt_nxt[1] = (x_act_r && !x_neg_r) ? xt : home_r;
    tgt_nxt[3] = (x_act_r &&  x_neg_r) ? xt : home_r;
    tgt_nxt[4] = lim((ANGLE_W+2)'(dflt_r) + (ANGLE_W+2)'(deg_rt_r), amin_r, amax_r);
    tgt_nxt[5] = lim((ANGLE_W+2)'(dflt_r) + (ANGLE_W+2)'(deg_lt_r), amin_r, amax_r);
    tgt_nxt[6] = item_r.hold_button
               ? lim((ANGLE_W+2)'(base_nxt) + (ANGLE_W+2)'(steps_r[31:24]), amin_r, amax_r)
               : base_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      base_r <= RST_SERVO;
    end else if (cmd.tgt) begin
      held_r <= item_r.hold_button;
      base_r <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tgt) tgt_r <= tgt_nxt;
  end

  // Slew limit and change detect
  logic [ANGLE_W-1:0] servo_nxt [NSERVO];
  logic               chg;
  logic               changed_r;

  always_comb begin
    chg = 1'b0;
    for (int i = 0; i < NSERVO; i++) begin
      if (i < 4)      servo_nxt[i] = slew(servo_r[i], tgt_r[i], steps_r[7:0]);
      else if (i < 6) servo_nxt[i] = slew(servo_r[i], tgt_r[i], steps_r[15:8]);
      else            servo_nxt[i] = slew(servo_r[i], tgt_r[i], steps_r[23:16]);
      if (servo_nxt[i] != servo_r[i]) chg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSERVO; i++) servo_r[i] <= RST_SERVO;
      changed_r <= 1'b0;
    end else if (cmd.slew) begin
      servo_r   <= servo_nxt;
      changed_r <= chg;
    end
  end
  assign st.changed = changed_r;

  // Output register
  out_item_t out_r;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.angle_up    <= servo_r[0];
      out_r.angle_right <= servo_r[1];
      out_r.angle_down  <= servo_r[2];
      out_r.angle_left  <= servo_r[3];
      out_r.angle_rtrig <= servo_r[4];
      out_r.angle_ltrig <= servo_r[5];
      out_r.angle_bump  <= servo_r[6];
    end
  end
  assign out_data = out_r;

endmodule

>>> rtl/joystick_servo_slew_mapper_top.sv
// Joystick to servo mapper. Each input transfer is one gamepad tick: the stick
// axes (with rescaled deadband) drive servos one to four around the home angle,
// the triggers drive servos five and six from the default angle, and the hold
// button latches and bumps servo seven. Stick, trigger and bump offsets are
// clamped to the angle limits and every target is slew limited; a result transfer
// carries all seven angles and is made only when one of them moved. A live tick
// stalls the input from its transfer until the sequencer is back in idle, so no
// new tick is taken before the last is done: each stick axis needs a multiply, a
// divider load, nine steps of the shared restoring divider and a store, each
// trigger a multiply and a store, then come the targets, the slew and the output
// register. A tick with pad_present low is taken without leaving idle and has no
// effect. The result sits in an output register, so the next tick can be taken
// while it waits; a tick that finishes while the previous result is still stalled
// waits. Registers may be written at any time the block is idle.
module joystick_servo_slew_mapper_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  jssm_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output jssm_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [jssm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jssm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import jssm_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencer
  jssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Arithmetic and servo state
  jssm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
